FILE: rtl/etw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etw_pkg
// shared types and constants for the eased value tween block
// ----------------------------------------------------------------------------
package etw_pkg;

  // tick counter and duration width
  localparam int TICK_BITS = 16;

  // configuration port
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [CFG_INDEX_BITS-1:0] REG_DURATION = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CURVE    = 1'd1;

  // item kinds
  localparam logic KIND_SET  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // easing curves
  localparam logic CURVE_LINEAR = 1'b0;
  localparam logic CURVE_EASE   = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_MUL_CURVE,
    ST_CURVE,
    ST_MUL_SPAN,
    ST_LEVEL,
    ST_EMIT
  } etw_state_t;

endpackage

FILE: rtl/eased_value_tween.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eased_value_tween
// animated value moving toward a target with linear or quadratic ease-in-out
// ----------------------------------------------------------------------------
// sequence: a set-target transaction goes from acceptance straight to the emit
//   state; a tick passes the check state and, while progress is incomplete, the
//   bit-serial progress divider, the curve and span multiplies and the level update
// throughput: one item at a time, the next is taken once the sequencer is idle
// reset: synchronous rst clears levels, tick count, configuration and output valid
// ----------------------------------------------------------------------------
module eased_value_tween
  import etw_pkg::*;
#(
  parameter int VALUE_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_write_en,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data,
  // input transactions
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          kind,
  input  logic signed [VALUE_BITS-1:0]  new_value,
  // output transactions
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [VALUE_BITS-1:0]  current_out,
  output logic                          finished
);

  // multiplier operand a holds the span magnitude, p, or 4 - 2p (F+2 bits)
  localparam int MUL_A = (VALUE_BITS > FRAC_BITS + 2) ? VALUE_BITS : FRAC_BITS + 2;
  localparam int PROD_BITS = MUL_A + FRAC_BITS;

  localparam logic [FRAC_BITS-1:0]  HALF_Q   = FRAC_BITS'(1) << (FRAC_BITS - 1);
  localparam logic [FRAC_BITS+1:0]  ONE_EXT  = (FRAC_BITS + 2)'(1) << FRAC_BITS;
  localparam logic [FRAC_BITS+2:0]  FOUR_EXT = (FRAC_BITS + 3)'(1) << (FRAC_BITS + 2);
  localparam logic [PROD_BITS:0]    ROUND_HALF = (PROD_BITS + 1)'(1) << (FRAC_BITS - 1);

  etw_state_t state, state_next;

  // configuration registers
  logic [TICK_BITS-1:0] duration_ticks;
  logic                 curve_mode;

  // tween state
  logic signed [VALUE_BITS-1:0] start_level;
  logic signed [VALUE_BITS-1:0] target_level;
  logic signed [VALUE_BITS-1:0] current_level;
  logic [TICK_BITS-1:0]         elapsed_ticks;

  // curve value, Q0.FRAC_BITS
  logic [FRAC_BITS-1:0] curve_q;

  // control
  logic accept;
  logic complete;
  logic div_start;
  logic div_done;
  logic mul_en;
  logic emit_load;

  logic [FRAC_BITS-1:0] progress;
  logic [MUL_A-1:0]     mul_a;
  logic [FRAC_BITS-1:0] mul_b;
  logic [PROD_BITS-1:0] prod;

  // set-target decode
  logic                 at_rest_repeat;
  logic                 reversal;
  logic [TICK_BITS-1:0] elapsed_clamped;

  // span and level arithmetic
  logic signed [VALUE_BITS:0] span;
  logic                       span_neg;
  logic [VALUE_BITS:0]        span_abs;
  logic [FRAC_BITS+2:0]       ease_hi_a;
  logic [FRAC_BITS+1:0]       ease_hi_c;
  logic [FRAC_BITS-1:0]       curve_calc;
  logic [PROD_BITS:0]         rounded;
  logic [VALUE_BITS-1:0]      step_mag;
  logic [VALUE_BITS:0]        level_sum;

  assign accept   = in_valid && in_ready;
  // progress counts as one when duration is zero or the count has caught up
  assign complete = (duration_ticks == '0) || (elapsed_ticks >= duration_ticks);

  // ---------------------------------------------------------------------------
  // configuration writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      duration_ticks <= '0;
      curve_mode     <= CURVE_LINEAR;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_DURATION: duration_ticks <= cfg_data[TICK_BITS-1:0];
        REG_CURVE:    curve_mode     <= cfg_data[0];
        default:      ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (kind == KIND_TICK) ? ST_CHECK : ST_EMIT;
        end
      end
      ST_CHECK:     state_next = complete ? ST_EMIT : ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_MUL_CURVE;
        end
      end
      ST_MUL_CURVE: state_next = ST_CURVE;
      ST_CURVE:     state_next = ST_MUL_SPAN;
      ST_MUL_SPAN:  state_next = ST_LEVEL;
      ST_LEVEL:     state_next = ST_EMIT;
      ST_EMIT: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer: outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    mul_en    = 1'b0;
    emit_load = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state)
      ST_IDLE:  in_ready  = 1'b1;
      ST_CHECK: div_start = !complete;
      ST_MUL_CURVE: begin
        // lower half of the ease uses p*p, upper half (4 - 2p)*p
        mul_en = 1'b1;
        mul_a  = (progress < HALF_Q) ? MUL_A'(progress) : MUL_A'(ease_hi_a[FRAC_BITS+1:0]);
        mul_b  = progress;
      end
      ST_MUL_SPAN: begin
        mul_en = 1'b1;
        mul_a  = MUL_A'(span_abs[VALUE_BITS-1:0]);
        mul_b  = curve_q;
      end
      ST_EMIT:  emit_load = !out_valid || out_ready;
      default:  ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // shared units
  // ---------------------------------------------------------------------------
  etw_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (elapsed_ticks),
    .divisor  (duration_ticks),
    .done     (div_done),
    .quotient (progress)
  );

  etw_mul #(
    .A_BITS (MUL_A),
    .B_BITS (FRAC_BITS)
  ) u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // ---------------------------------------------------------------------------
  // datapath arithmetic
  // ---------------------------------------------------------------------------
  assign ease_hi_a = FOUR_EXT - {1'b0, progress, 1'b0};
  assign ease_hi_c = prod[FRAC_BITS +: FRAC_BITS+2] - ONE_EXT;

  always_comb begin
    if (curve_mode == CURVE_LINEAR) begin
      curve_calc = progress;
    end else if (progress < HALF_Q) begin
      curve_calc = prod[FRAC_BITS-1 +: FRAC_BITS];
    end else begin
      curve_calc = ease_hi_c[FRAC_BITS-1:0];
    end
  end

  // span magnitude always fits VALUE_BITS bits
  assign span     = {target_level[VALUE_BITS-1], target_level}
                  - {start_level[VALUE_BITS-1], start_level};
  assign span_neg = span[VALUE_BITS];
  assign span_abs = span_neg ? (~span + 1'b1) : span;

  // round half away from zero on the magnitude
  assign rounded   = {1'b0, prod} + ROUND_HALF;
  assign step_mag  = rounded[FRAC_BITS +: VALUE_BITS];
  assign level_sum = span_neg
                   ? ({start_level[VALUE_BITS-1], start_level} - {1'b0, step_mag})
                   : ({start_level[VALUE_BITS-1], start_level} + {1'b0, step_mag});

  // set-target decisions
  assign at_rest_repeat  = (new_value == target_level) && (current_level == target_level);
  assign reversal        = (new_value == start_level);
  assign elapsed_clamped = (elapsed_ticks < duration_ticks) ? elapsed_ticks : duration_ticks;

  // ---------------------------------------------------------------------------
  // tween state update
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      start_level   <= '0;
      target_level  <= '0;
      current_level <= '0;
      elapsed_ticks <= '0;
    end else begin
      if (accept) begin
        if (kind == KIND_TICK) begin
          // advance, saturating at the duration
          elapsed_ticks <= (elapsed_ticks < duration_ticks)
                         ? elapsed_ticks + TICK_BITS'(1) : duration_ticks;
        end else if (at_rest_repeat) begin
          // repeat of the target while resting there: nothing changes
        end else if (reversal) begin
          // swap ends and mirror the elapsed count
          start_level   <= target_level;
          target_level  <= new_value;
          elapsed_ticks <= duration_ticks - elapsed_clamped;
        end else begin
          start_level   <= current_level;
          target_level  <= new_value;
          elapsed_ticks <= '0;
        end
      end
      if (state == ST_CHECK && complete) begin
        current_level <= target_level;
      end
      if (state == ST_LEVEL) begin
        current_level <= level_sum[VALUE_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_CURVE) begin
      curve_q <= curve_calc;
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      current_out <= current_level;
      finished    <= complete;
    end
  end

endmodule

FILE: rtl/etw_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etw_div
// radix-2 restoring divider: (dividend << FRAC_BITS) / divisor, one bit a cycle
// ----------------------------------------------------------------------------
module etw_div
  import etw_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [TICK_BITS-1:0] dividend,
  input  logic [TICK_BITS-1:0] divisor,
  output logic                 done,
  output logic [FRAC_BITS-1:0] quotient
);

  localparam int CNT_BITS = $clog2(FRAC_BITS + 1);

  logic                busy;
  logic [CNT_BITS-1:0] cnt;
  logic [TICK_BITS-1:0] rem;
  logic [TICK_BITS:0]   rem_shift;
  logic [TICK_BITS:0]   rem_diff;
  logic                 take;

  // dividend must be below divisor, so the remainder stays under 16 bits
  assign rem_shift = {rem, 1'b0};
  assign rem_diff  = rem_shift - {1'b0, divisor};
  assign take      = (rem_shift >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_BITS'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt      <= CNT_BITS'(FRAC_BITS);
      rem      <= dividend;
      quotient <= '0;
    end else if (busy) begin
      cnt      <= cnt - CNT_BITS'(1);
      rem      <= take ? rem_diff[TICK_BITS-1:0] : rem_shift[TICK_BITS-1:0];
      quotient <= {quotient[FRAC_BITS-2:0], take};
    end
  end

endmodule

FILE: rtl/etw_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etw_mul
// shared unsigned multiplier with registered product
// ----------------------------------------------------------------------------
module etw_mul #(
  parameter int A_BITS = 18,
  parameter int B_BITS = 16
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [A_BITS-1:0]        a,
  input  logic [B_BITS-1:0]        b,
  output logic [A_BITS+B_BITS-1:0] prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * b;
    end
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the eased value tween: a table of directed items
// first, then random phases of target changes and ticks under random
// durations and curves, each result compared with an in-bench tween model
// ----------------------------------------------------------------------------
module tb;
  import etw_pkg::*;

  localparam int FRAC = 16;
  localparam longint unsigned ONE = 64'd1 << FRAC;
  localparam longint unsigned HALF = ONE >> 1;
  localparam int N_PHASES = 15;
  localparam int PHASE_ITEMS = 70;
  localparam int LONG_HOLD = 400;
  localparam int CYCLE_LIMIT = 1000000;

  // one expected result
  typedef struct packed {
    logic signed [15:0] level;
    logic               done;
  } result_t;

  // directed table row: either a register write or one input transaction
  typedef struct packed {
    bit                        is_cfg;
    logic [CFG_INDEX_BITS-1:0] idx;
    logic [CFG_DATA_BITS-1:0]  data;
    logic                      kind;
    logic signed [15:0]        value;
    bit                        typed;
    logic signed [15:0]        want_level;
    logic                      want_done;
  } row_t;

  // receiver stall patterns
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE
  } rx_mode_t;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      cfg_write_en;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;
  logic                      in_valid;
  logic                      in_ready;
  logic                      kind;
  logic signed [15:0]        new_value;
  logic                      out_valid;
  logic                      out_ready;
  logic signed [15:0]        current_out;
  logic                      finished;

  // tween model state and its copy of the registers
  int unsigned dur_reg;
  bit          ease_reg;
  int          start_lv;
  int          target_lv;
  int          cur_lv;
  int unsigned elapsed;

  result_t level_q[$];     // results still owed by the block
  int      fail_cnt;
  int      cycle_cnt;
  int      burst_left;
  bit      hold_off_req;   // main process asks the receiver for a long hold-off
  int      hold_cnt;
  int      stall_left;
  rx_mode_t stall_mode;

  eased_value_tween i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .new_value    (new_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .current_out  (current_out),
    .finished     (finished)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               level_q.size());
      $display("tb: failure");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // tween model
  // --------------------------------------------------------------------------

  // progress in Q0.16, saturating at one
  function automatic longint unsigned progress_now();
    if (dur_reg == 0 || elapsed >= dur_reg) begin
      return ONE;
    end
    return (longint'(elapsed) << FRAC) / longint'(dur_reg);
  endfunction

  // easing curve applied to a progress below one
  function automatic longint unsigned eased(input longint unsigned p);
    if (!ease_reg) begin
      return p;
    end
    if (p < HALF) begin
      return (2 * p * p) >> FRAC;
    end
    return (((4 * ONE - 2 * p) * p) >> FRAC) - ONE;
  endfunction

  // advance the model by one transaction and give the level and done flag
  task automatic tween_step(input logic k, input logic signed [15:0] v,
                            output result_t r);
    int              tv;
    int unsigned     e;
    longint          span;
    longint unsigned p;
    longint unsigned c;
    longint unsigned q;
    tv = int'(v);
    if (k == KIND_SET) begin
      if (tv == target_lv && cur_lv == target_lv) begin
        // already resting on this target
      end else if (tv == start_lv) begin
        // heading back where it came from: mirror the elapsed count
        e = (elapsed < dur_reg) ? elapsed : dur_reg;
        start_lv  = target_lv;
        target_lv = tv;
        elapsed   = dur_reg - e;
      end else begin
        start_lv  = cur_lv;
        target_lv = tv;
        elapsed   = 0;
      end
    end else begin
      if (elapsed < dur_reg) begin
        elapsed++;
      end else begin
        elapsed = dur_reg;
      end
      p = progress_now();
      if (p >= ONE) begin
        cur_lv = target_lv;
      end else begin
        span = longint'(target_lv) - longint'(start_lv);
        c = eased(p);
        // round half away from zero on the magnitude
        if (span < 0) begin
          q = ((unsigned'(-span) * c) + HALF) >> FRAC;
          cur_lv = start_lv - int'(q);
        end else begin
          q = ((unsigned'(span) * c) + HALF) >> FRAC;
          cur_lv = start_lv + int'(q);
        end
      end
    end
    r.level = cur_lv[15:0];
    r.done  = (progress_now() == ONE);
  endtask

  // --------------------------------------------------------------------------
  // driving helpers, all entered and left at a falling edge
  // --------------------------------------------------------------------------

  // one input transaction; typed expectations override the model's output
  task automatic send_item(input logic k, input logic signed [15:0] v, input bit typed,
                           input logic signed [15:0] want_level, input logic want_done);
    result_t r;
    int      gap;
    in_valid  = 1'b1;
    kind      = k;
    new_value = v;
    do @(posedge clk); while (!in_ready);
    tween_step(k, v, r);
    if (typed) begin
      r.level = want_level;
      r.done  = want_done;
    end
    level_q.push_back(r);
    @(negedge clk);
    // bursts of back-to-back transactions with random gaps between them
    if (burst_left > 0) begin
      burst_left--;
    end
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // stop offering, let every owed result arrive, then settle
  task automatic wait_idle(input int settle);
    in_valid = 1'b0;
    while (level_q.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  // register write, mirrored into the model
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_write_en = 1'b1;
    cfg_index    = idx;
    cfg_data     = data;
    @(negedge clk);
    cfg_write_en = 1'b0;
    if (idx == REG_DURATION) begin
      dur_reg = data;
    end else begin
      ease_reg = data[0];
    end
  endtask

  function automatic row_t cfg_row(input logic [CFG_INDEX_BITS-1:0] idx,
                                   input logic [CFG_DATA_BITS-1:0] data);
    row_t w;
    w = '0;
    w.is_cfg = 1'b1;
    w.idx    = idx;
    w.data   = data;
    return w;
  endfunction

  function automatic row_t item_row(input logic k, input logic signed [15:0] v,
                                    input bit typed, input logic signed [15:0] lvl,
                                    input logic done);
    row_t w;
    w = '0;
    w.kind       = k;
    w.value      = v;
    w.typed      = typed;
    w.want_level = lvl;
    w.want_done  = done;
    return w;
  endfunction

  task automatic report(input string what, input logic signed [15:0] got,
                        input logic signed [15:0] want);
    if (fail_cnt < 40) begin
      $display("mismatch on %s at cycle %0d: got %0d, want %0d", what, cycle_cnt, got,
               want);
    end
    fail_cnt++;
  endtask

  // --------------------------------------------------------------------------
  // result checker
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (level_q.size() == 0) begin
        report("unexpected result", current_out, 16'sd0);
      end else begin
        want = level_q.pop_front();
        if (current_out !== want.level) begin
          report("current_out", current_out, want.level);
        end
        if (finished !== want.done) begin
          report("finished", {15'd0, finished}, {15'd0, want.done});
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // receiver: changing stall patterns, plus one long hold-off on request
  // --------------------------------------------------------------------------
  always begin
    @(negedge clk);
    if (hold_off_req) begin
      // the block keeps one result and must stall its input meanwhile
      out_ready = 1'b0;
      hold_cnt = 0;
      while (hold_cnt < LONG_HOLD) begin
        @(negedge clk);
        hold_cnt++;
      end
      hold_off_req = 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = rx_mode_t'($urandom_range(0, 2));
        stall_left = $urandom_range(20, 80);
      end
      stall_left--;
      case (stall_mode)
        RX_OPEN: begin
          out_ready = 1'b1;
        end
        RX_COIN: begin
          out_ready = ($urandom_range(0, 1) != 0);
        end
        default: begin
          out_ready = ($urandom_range(0, 3) == 0);
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    row_t               dir_tab[$];
    row_t               w;
    int                 ph;
    int                 n;
    logic [15:0]        dur_pick;
    logic               k;
    logic signed [15:0] v;

    rst          = 1'b1;
    cfg_write_en = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    kind         = KIND_SET;
    new_value    = '0;
    out_ready    = 1'b0;
    fail_cnt     = 0;
    cycle_cnt    = 0;
    burst_left   = 1;
    hold_off_req = 1'b0;
    stall_left   = 0;
    stall_mode   = RX_OPEN;
    dur_reg      = 0;
    ease_reg     = 1'b0;
    start_lv     = 0;
    target_lv    = 0;
    cur_lv       = 0;
    elapsed      = 0;

    // zero duration after reset: every level jumps straight to its target
    dir_tab.push_back(item_row(KIND_TICK, 16'sd0, 1'b1, 16'sd0, 1'b1));
    dir_tab.push_back(item_row(KIND_SET, 16'sh7fff, 1'b1, 16'sd0, 1'b1));
    dir_tab.push_back(item_row(KIND_TICK, 16'sd0, 1'b1, 16'sh7fff, 1'b1));
    // same target again while resting on it
    dir_tab.push_back(item_row(KIND_SET, 16'sh7fff, 1'b1, 16'sh7fff, 1'b1));
    dir_tab.push_back(item_row(KIND_SET, -16'sh8000, 1'b1, 16'sh7fff, 1'b1));
    dir_tab.push_back(item_row(KIND_TICK, 16'sh7fff, 1'b1, -16'sh8000, 1'b1));
    // target equal to the start: reversal with nothing elapsed
    dir_tab.push_back(item_row(KIND_SET, 16'sh7fff, 1'b1, -16'sh8000, 1'b1));
    dir_tab.push_back(item_row(KIND_TICK, 16'sd0, 1'b1, 16'sh7fff, 1'b1));
    // short linear transition; reversal mirrors zero elapsed to complete
    dir_tab.push_back(cfg_row(REG_DURATION, 16'd4));
    dir_tab.push_back(cfg_row(REG_CURVE, {15'd0, CURVE_LINEAR}));
    dir_tab.push_back(item_row(KIND_SET, -16'sh8000, 1'b1, 16'sh7fff, 1'b1));
    dir_tab.push_back(item_row(KIND_TICK, 16'sd0, 1'b1, -16'sh8000, 1'b1));
    dir_tab.push_back(item_row(KIND_SET, 16'sd0, 1'b0, 16'sd0, 1'b0));
    dir_tab.push_back(item_row(KIND_TICK, 16'sd0, 1'b0, 16'sd0, 1'b0));
    dir_tab.push_back(item_row(KIND_TICK, 16'sd0, 1'b0, 16'sd0, 1'b0));
    // reversal halfway through
    dir_tab.push_back(item_row(KIND_SET, -16'sh8000, 1'b0, 16'sd0, 1'b0));
    dir_tab.push_back(item_row(KIND_TICK, 16'sd0, 1'b0, 16'sd0, 1'b0));
    // longest duration with the eased curve
    dir_tab.push_back(cfg_row(REG_CURVE, {15'd0, CURVE_EASE}));
    dir_tab.push_back(cfg_row(REG_DURATION, 16'hffff));
    dir_tab.push_back(item_row(KIND_SET, 16'sh7fff, 1'b0, 16'sd0, 1'b0));
    dir_tab.push_back(item_row(KIND_TICK, 16'sd0, 1'b0, 16'sd0, 1'b0));
    dir_tab.push_back(item_row(KIND_TICK, 16'sd0, 1'b0, 16'sd0, 1'b0));
    dir_tab.push_back(item_row(KIND_TICK, 16'sd0, 1'b0, 16'sd0, 1'b0));
    // duration lowered below the elapsed count: the next tick lands on target
    dir_tab.push_back(cfg_row(REG_DURATION, 16'd1));
    dir_tab.push_back(item_row(KIND_TICK, 16'sd0, 1'b1, 16'sh7fff, 1'b1));
    // odd duration so the eased curve crosses its midpoint between ticks
    dir_tab.push_back(cfg_row(REG_DURATION, 16'd7));
    dir_tab.push_back(item_row(KIND_SET, -16'sh8000, 1'b0, 16'sd0, 1'b0));
    dir_tab.push_back(item_row(KIND_TICK, 16'sd0, 1'b0, 16'sd0, 1'b0));
    dir_tab.push_back(item_row(KIND_TICK, 16'sd0, 1'b0, 16'sd0, 1'b0));
    dir_tab.push_back(item_row(KIND_TICK, 16'sd0, 1'b0, 16'sd0, 1'b0));
    dir_tab.push_back(item_row(KIND_TICK, 16'sd0, 1'b0, 16'sd0, 1'b0));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    foreach (dir_tab[j]) begin
      w = dir_tab[j];
      if (w.is_cfg) begin
        wait_idle(4);
        write_reg(w.idx, w.data);
      end else begin
        send_item(w.kind, w.value, w.typed, w.want_level, w.want_done);
      end
    end

    // random phases, each under its own duration and curve
    for (ph = 0; ph < N_PHASES; ph++) begin
      wait_idle(4);
      case ($urandom_range(0, 9))
        0: begin
          dur_pick = 16'd0;
        end
        1: begin
          dur_pick = 16'd1;
        end
        2: begin
          dur_pick = 16'hffff;
        end
        3: begin
          dur_pick = 16'($urandom);
        end
        default: begin
          dur_pick = 16'($urandom_range(2, 40));
        end
      endcase
      if (ph == 1) begin
        dur_pick = 16'd0;
      end else if (ph == 2) begin
        dur_pick = 16'hffff;
      end
      write_reg(REG_DURATION, dur_pick);
      write_reg(REG_CURVE, {15'd0, ($urandom_range(0, 1) != 0) ? CURVE_EASE : CURVE_LINEAR});
      if (ph == 5) begin
        hold_off_req = 1'b1;
      end
      for (n = 0; n < PHASE_ITEMS; n++) begin
        v = 16'($urandom);
        if ($urandom_range(0, 3) == 0) begin
          k = KIND_SET;
          // nearly half reversals and repeats so the special paths see real traffic
          case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5: begin
              v = start_lv[15:0];
            end
            6, 7, 8: begin
              v = target_lv[15:0];
            end
            9: begin
              v = ($urandom_range(0, 1) != 0) ? 16'sh7fff : -16'sh8000;
            end
            10: begin
              v = ($urandom_range(0, 1) != 0) ? 16'sd0 : -16'sd1;
            end
            default: begin
            end
          endcase
        end else begin
          k = KIND_TICK;
        end
        send_item(k, v, 1'b0, 16'sd0, 1'b0);
      end
    end

    // drain and give any stray result time to show up
    wait_idle(40);
    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
